[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

[rtl/dsll_pkg.sv]
package dsll_pkg;

  localparam int KeyW    = 32;
  localparam int TagW    = 16;
  localparam int KindW   = 2;
  localparam int StatusW = 3;

  typedef enum logic [KindW-1:0] {
    KindPush  = 2'd0,
    KindEmit  = 2'd1,
    KindClear = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    StsAccepted = 3'd0,
    StsDup      = 3'd1,
    StsFull     = 3'd2,
    StsEntry    = 3'd3,
    StsEmpty    = 3'd4,
    StsCleared  = 3'd5
  } status_e;

  typedef enum logic {
    StIdle = 1'b0,
    StEmit = 1'b1
  } state_e;

  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic push;
    logic rotate;
    logic clear;
  } cell_ctrl_t;

endpackage

[rtl/dsll_cell.sv]
module dsll_cell
  import dsll_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctrl_t      ctrl_i,
  input  logic [KeyW-1:0] new_key_i,
  input  logic [TagW-1:0] new_tag_i,
  input  entry_t          left_i,
  input  logic            left_ins_i,
  input  entry_t          right_i,
  input  entry_t          head_i,
  output entry_t          ent_o,
  output logic            ins_o,
  output logic            dup_o
);

  entry_t ent_q, ent_d;

  assign ent_o = ent_q;
  assign ins_o = !ent_q.valid || (ent_q.key > new_key_i);
  assign dup_o = ent_q.valid && (ent_q.key == new_key_i);

  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.clear) begin
      ent_d.valid = 1'b0;
    end else if (ctrl_i.push) begin
      if (ins_o) begin
        if (left_ins_i) begin
          ent_d = left_i;
        end else begin
          ent_d.valid = 1'b1;
          ent_d.key   = new_key_i;
          ent_d.tag   = new_tag_i;
        end
      end
    end else if (ctrl_i.rotate) begin
      // advance towards the head; the last valid cell takes the head back
      if (ent_q.valid) begin
        if (right_i.valid) begin
          ent_d = right_i;
        end else begin
          ent_d = head_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

endmodule

[rtl/dedup_sort_line_list.sv]
// Sorted, deduplicated list of (line number, tag) words held in a chain of
// compare cells.
// Input channel: in_valid_i / in_stall_o with kind_i, line_number_i and
// payload_tag_i. Output channel: out_valid_o / out_stall_i with status_o,
// out_line_number_o, out_tag_o and last_o.
// A push, a clear or an emit of an empty list gives one result word, shown
// in the cycle after acceptance; the next input word may follow at once.
// A duplicate or full push is dropped with its status.
// An emit of n entries gives n words in ascending order, loaded in the emit
// state after acceptance, one per cycle while the receiver does not stall;
// the chain rotates its valid part by one cell per word, so the list is back
// in place after the last word. The input stalls until that last word is loaded.
// Kind 3 is taken and ignored.
// When the receiver stalls, the output register holds its word and the input
// stalls too; nothing is lost.
// Reset clears every cell's valid bit, the entry count and the output valid;
// the list is usable in the first cycle after reset.
`include "assert_macros.svh"

module dedup_sort_line_list
  import dsll_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [KindW-1:0]   kind_i,
  input  logic [KeyW-1:0]    line_number_i,
  input  logic [TagW-1:0]    payload_tag_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [StatusW-1:0] status_o,
  output logic [KeyW-1:0]    out_line_number_o,
  output logic [TagW-1:0]    out_tag_o,
  output logic               last_o
);

  localparam int CntW = $clog2(DEPTH + 1);

  entry_t     ent   [DEPTH];
  logic       ins   [DEPTH];
  logic [DEPTH-1:0] dup_vec;
  logic [DEPTH-1:0] valid_vec;
  cell_ctrl_t ctrl;

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] remain_q, remain_d;

  logic            out_valid_q, out_valid_d;
  status_e         status_q, status_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [TagW-1:0] tag_q, tag_d;
  logic            last_q, last_d;

  logic in_acc, out_free, emit_step, load, dup_any, full;

  entry_t no_entry;
  assign no_entry = '0;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      entry_t left_ent, right_ent;
      logic   left_ins;
      if (gi == 0) begin : g_first
        assign left_ent = no_entry;
        assign left_ins = 1'b0;
      end else begin : g_mid
        assign left_ent = ent[gi-1];
        assign left_ins = ins[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_ent = no_entry;
      end else begin : g_nlast
        assign right_ent = ent[gi+1];
      end
      dsll_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (ctrl),
        .new_key_i  (line_number_i),
        .new_tag_i  (payload_tag_i),
        .left_i     (left_ent),
        .left_ins_i (left_ins),
        .right_i    (right_ent),
        .head_i     (ent[0]),
        .ent_o      (ent[gi]),
        .ins_o      (ins[gi]),
        .dup_o      (dup_vec[gi])
      );
      assign valid_vec[gi] = ent[gi].valid;
    end
  endgenerate

  assign dup_any  = |dup_vec;
  assign full     = ent[DEPTH-1].valid;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_acc   = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc && (kind_e'(kind_i) == KindEmit) && (count_q != '0)) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (emit_step && (remain_q == CntW'(1))) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    emit_step  = 1'b0;
    ctrl       = '0;
    load       = 1'b0;
    status_d   = status_q;
    key_d      = '0;
    tag_d      = '0;
    last_d     = 1'b1;
    count_d    = count_q;
    remain_d   = remain_q;
    case (state_q)
      StIdle: begin
        in_stall_o = out_valid_q && out_stall_i;
        if (in_valid_i && !in_stall_o) begin
          case (kind_e'(kind_i))
            KindPush: begin
              load = 1'b1;
              if (dup_any) begin
                status_d = StsDup;
              end else if (full) begin
                status_d = StsFull;
              end else begin
                status_d  = StsAccepted;
                ctrl.push = 1'b1;
                count_d   = count_q + CntW'(1);
              end
            end
            KindEmit: begin
              if (count_q == '0) begin
                load     = 1'b1;
                status_d = StsEmpty;
              end else begin
                remain_d = count_q;
              end
            end
            KindClear: begin
              load       = 1'b1;
              status_d   = StsCleared;
              ctrl.clear = 1'b1;
              count_d    = '0;
            end
            default: ;
          endcase
        end
      end
      StEmit: begin
        emit_step = out_free;
        if (out_free) begin
          load        = 1'b1;
          status_d    = StsEntry;
          key_d       = ent[0].key;
          tag_d       = ent[0].tag;
          last_d      = (remain_q == CntW'(1));
          ctrl.rotate = 1'b1;
          remain_d    = remain_q - CntW'(1);
        end
      end
      default: ;
    endcase
    out_valid_d = load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= status_d;
      key_q    <= key_d;
      tag_q    <= tag_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign out_line_number_o = key_q;
  assign out_tag_o         = tag_q;
  assign last_o            = last_q;

  `ASSERT_SAME(a_emit_stalls_input, clk_i, rst_ni, state_q == StEmit, in_stall_o)
  `ASSERT_SAME(a_count_matches_cells, clk_i, rst_ni, 1'b1,
               $countones(valid_vec) == int'(count_q))
  `ASSERT_NEXT(a_dup_reported, clk_i, rst_ni,
               in_acc && (kind_e'(kind_i) == KindPush) && dup_any,
               out_valid_q && (status_q == StsDup) && last_q)
  `ASSERT_SAME(a_emit_last_ends, clk_i, rst_ni,
               (state_q == StEmit) && (remain_q == '0), 1'b0)

endmodule
